### hdl/pkr_pkg.sv
// Shared types and constants of the plucked string resonator.
package pkr_pkg;

  localparam int DELAY_BITS  = 12;
  localparam int WEIGHT_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int GAIN_BITS   = 16;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 5;
  localparam int REG_IDX_BITS  = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_ENABLED        = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_DELAY_LENGTH   = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_LOWPASS_WEIGHT = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_ALLPASS_COEF   = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_FEEDBACK_GAIN  = 3'd4;

  localparam logic                          RST_ENABLED        = 1'b1;
  localparam logic [DELAY_BITS-1:0]         RST_DELAY_LENGTH   = 12'd100;
  localparam logic [WEIGHT_BITS-1:0]        RST_LOWPASS_WEIGHT = 16'd32768;
  localparam logic signed [COEF_BITS-1:0]   RST_ALLPASS_COEF   = 16'sd0;
  localparam logic [GAIN_BITS-1:0]          RST_FEEDBACK_GAIN  = 16'd0;

  typedef struct packed {
    logic                        enabled;
    logic [DELAY_BITS-1:0]       delay_length;
    logic [WEIGHT_BITS-1:0]      lowpass_weight;
    logic signed [COEF_BITS-1:0] allpass_coef;
    logic [GAIN_BITS-1:0]        feedback_gain;
  } cfg_t;

endpackage

### hdl/pkr_if.sv
// Stream interfaces for the sample words entering and leaving the resonator.
interface pkr_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface pkr_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

### hdl/plucked_string_resonator.sv
// Top level of the plucked string resonator.
// A plucked string resonator: each input word is added to a tap read delay_length words back
// from a circular store of STORE_DEPTH entries (a power of two; the delay is taken modulo the
// depth), passed through a weighted two-point lowpass and a first-order allpass, and sent out;
// the result, scaled by the feedback gain and saturated, is written back into the store. An
// enabled word presents its result after the registered store read and the separate multiply
// and add steps of the lowpass and allpass, and the next word is taken only after the
// write-back into the store; a word taken while disabled presents zero, frees the input in
// the same cycle that the zero is presented and leaves the state untouched. A waiting result
// stalls the block only when the next result is ready before the previous one is taken. After
// reset the store is cleared in a sweep over all STORE_DEPTH entries during which no word is
// accepted; the APB registers can be written throughout and should only be changed while the
// block is idle.
module plucked_string_resonator #(
  parameter int STORE_DEPTH = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  pkr_in_if.sink                             in_if,
  pkr_out_if.source                          out_if,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pkr_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [pkr_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [pkr_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);

  localparam int ADDR_BITS = $clog2(STORE_DEPTH);

  pkr_pkg::cfg_t                 cfg;
  logic                          clear_busy;
  logic                          rd_en;
  logic [ADDR_BITS-1:0]          rd_addr;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic                          wr_en;
  logic [ADDR_BITS-1:0]          wr_addr;
  logic signed [SAMPLE_BITS-1:0] wr_data;

  pkr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pkr_loop_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .clear_busy (clear_busy)
  );

  pkr_core #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .clear_busy (clear_busy),
    .in_if      (in_if),
    .out_if     (out_if),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready |-> !clear_busy)
    else $error("Input word taken during the store clearing sweep.");

  a_no_core_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !clear_busy)
    else $error("Loop write collides with the store clearing sweep.");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> clear_busy)
    else $error("Store clearing sweep did not start after reset.");

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("A second word was offered a slot while one is in progress.");

endmodule

### hdl/pkr_cfg_regs.sv
// APB register bank holding the resonator settings.
module pkr_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pkr_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [pkr_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [pkr_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  output pkr_pkg::cfg_t                      cfg
);

  pkr_pkg::cfg_t                         cfg_r;
  logic [pkr_pkg::REG_IDX_BITS-1:0]      idx;
  logic                                  wr;

  assign idx    = paddr[pkr_pkg::APB_ADDR_BITS-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled        <= pkr_pkg::RST_ENABLED;
      cfg_r.delay_length   <= pkr_pkg::RST_DELAY_LENGTH;
      cfg_r.lowpass_weight <= pkr_pkg::RST_LOWPASS_WEIGHT;
      cfg_r.allpass_coef   <= pkr_pkg::RST_ALLPASS_COEF;
      cfg_r.feedback_gain  <= pkr_pkg::RST_FEEDBACK_GAIN;
    end else if (wr) begin
      case (idx)
        pkr_pkg::REG_ENABLED:        cfg_r.enabled <= pwdata[0];
        pkr_pkg::REG_DELAY_LENGTH:   cfg_r.delay_length <= pwdata[pkr_pkg::DELAY_BITS-1:0];
        pkr_pkg::REG_LOWPASS_WEIGHT: cfg_r.lowpass_weight <= pwdata[pkr_pkg::WEIGHT_BITS-1:0];
        pkr_pkg::REG_ALLPASS_COEF:   cfg_r.allpass_coef <= pwdata[pkr_pkg::COEF_BITS-1:0];
        pkr_pkg::REG_FEEDBACK_GAIN:  cfg_r.feedback_gain <= pwdata[pkr_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      pkr_pkg::REG_ENABLED:        prdata[0] = cfg_r.enabled;
      pkr_pkg::REG_DELAY_LENGTH:   prdata[pkr_pkg::DELAY_BITS-1:0] = cfg_r.delay_length;
      pkr_pkg::REG_LOWPASS_WEIGHT: prdata[pkr_pkg::WEIGHT_BITS-1:0] = cfg_r.lowpass_weight;
      pkr_pkg::REG_ALLPASS_COEF:   prdata[pkr_pkg::COEF_BITS-1:0] = cfg_r.allpass_coef;
      pkr_pkg::REG_FEEDBACK_GAIN:  prdata[pkr_pkg::GAIN_BITS-1:0] = cfg_r.feedback_gain;
      default: prdata = '0;
    endcase
  end

endmodule

### hdl/pkr_loop_store.sv
// Circular delay store with registered read and a clearing sweep after reset.
module pkr_loop_store #(
  parameter int STORE_DEPTH = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  wr_en,
  input  logic [$clog2(STORE_DEPTH)-1:0]        wr_addr,
  input  logic signed [SAMPLE_BITS-1:0]         wr_data,
  input  logic                                  rd_en,
  input  logic [$clog2(STORE_DEPTH)-1:0]        rd_addr,
  output logic signed [SAMPLE_BITS-1:0]         rd_data,
  output logic                                  clear_busy
);

  localparam int ADDR_BITS = $clog2(STORE_DEPTH);

  logic signed [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic [ADDR_BITS-1:0]          clr_addr_r;
  logic                          clr_busy_r;

  assign rd_data    = rd_data_r;
  assign clear_busy = clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_BITS'(STORE_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

### hdl/pkr_core.sv
// Sequencer and arithmetic of the string loop: lowpass, allpass and feedback write.
module pkr_core #(
  parameter int STORE_DEPTH = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pkr_pkg::cfg_t                     cfg,
  input  logic                              clear_busy,
  pkr_in_if.sink                            in_if,
  pkr_out_if.source                         out_if,
  output logic                              rd_en,
  output logic [$clog2(STORE_DEPTH)-1:0]    rd_addr,
  input  logic signed [SAMPLE_BITS-1:0]     rd_data,
  output logic                              wr_en,
  output logic [$clog2(STORE_DEPTH)-1:0]    wr_addr,
  output logic signed [SAMPLE_BITS-1:0]     wr_data
);

  localparam int S         = SAMPLE_BITS;
  localparam int ADDR_BITS = $clog2(STORE_DEPTH);
  localparam int DLY_BITS  = (ADDR_BITS > pkr_pkg::DELAY_BITS) ? ADDR_BITS
                                                                : pkr_pkg::DELAY_BITS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUM, ST_LPMUL, ST_LPADD, ST_APMUL, ST_OUT, ST_PUT, ST_WB
  } state_t;

  state_t                 state_r;
  logic [ADDR_BITS-1:0]   wr_idx_r;
  logic signed [S:0]      lp_prev_r;
  logic signed [S+1:0]    ap_prev_r;
  logic                   zero_r;
  logic                   out_valid_r;
  logic signed [S-1:0]    out_data_r;

  logic signed [S-1:0]    x_r;
  logic signed [S:0]      w_r;
  logic signed [S+1:0]    diff_r;
  logic signed [S+18:0]   lp_prod_r;
  logic signed [S:0]      y_r;
  logic signed [S+16:0]   ap_prod_r;
  logic signed [S-1:0]    o_r;
  logic signed [S+15:0]   ap2_prod_r;
  logic signed [S+16:0]   fb_prod_r;

  logic                   accept;
  logic [DLY_BITS-1:0]    dly_ext;
  logic signed [16:0]     weight_s;
  logic signed [16:0]     gain_s;
  logic signed [S:0]      w_c;
  logic signed [S+1:0]    diff_c;
  logic signed [S+19:0]   y_sum_c;
  logic signed [S:0]      y_c;
  logic signed [S+17:0]   t1_sum_c;
  logic signed [S+2:0]    t1_c;
  logic signed [S+3:0]    o_sum_c;
  logic                   o_ovf;
  logic signed [S-1:0]    o_c;
  logic signed [S+16:0]   t2_sum_c;
  logic signed [S+1:0]    t2_c;
  logic signed [S+2:0]    ap_new_c;
  logic                   ap_ovf;
  logic signed [S+1:0]    ap_sat_c;
  logic signed [S+17:0]   fb_sum_c;
  logic signed [S+1:0]    fb_c;
  logic                   fb_ovf;
  logic signed [S-1:0]    fb_sat_c;

  assign in_if.ready       = (state_r == ST_IDLE) && !clear_busy;
  assign accept            = in_if.valid && in_if.ready;
  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = out_data_r;

  assign dly_ext  = DLY_BITS'(cfg.delay_length);
  assign rd_en    = accept && cfg.enabled;
  assign rd_addr  = wr_idx_r - dly_ext[ADDR_BITS-1:0];
  assign weight_s = $signed({1'b0, cfg.lowpass_weight});
  assign gain_s   = $signed({1'b0, cfg.feedback_gain});

  assign w_c    = (S+1)'(rd_data) + (S+1)'(x_r);
  assign diff_c = (S+2)'(w_c) - (S+2)'(lp_prev_r);

  assign y_sum_c = ((S+20)'(lp_prev_r) <<< 16) + (S+20)'(lp_prod_r) + (S+20)'(32768);
  assign y_c     = y_sum_c[S+16:16];

  assign t1_sum_c = (S+18)'(ap_prod_r) + (S+18)'(16384);
  assign t1_c     = t1_sum_c[S+17:15];
  assign o_sum_c  = (S+4)'(ap_prev_r) + (S+4)'(t1_c);
  assign o_ovf    = !((&o_sum_c[S+3:S-1]) || !(|o_sum_c[S+3:S-1]));
  assign o_c      = o_ovf ? {o_sum_c[S+3], {(S-1){~o_sum_c[S+3]}}} : o_sum_c[S-1:0];

  assign t2_sum_c = (S+17)'(ap2_prod_r) + (S+17)'(16384);
  assign t2_c     = t2_sum_c[S+16:15];
  assign ap_new_c = (S+3)'(y_r) - (S+3)'(t2_c);
  assign ap_ovf   = ap_new_c[S+2] != ap_new_c[S+1];
  assign ap_sat_c = ap_ovf ? {ap_new_c[S+2], {(S+1){~ap_new_c[S+2]}}} : ap_new_c[S+1:0];

  assign fb_sum_c = (S+18)'(fb_prod_r) + (S+18)'(32768);
  assign fb_c     = fb_sum_c[S+17:16];
  assign fb_ovf   = !((&fb_c[S+1:S-1]) || !(|fb_c[S+1:S-1]));
  assign fb_sat_c = fb_ovf ? {fb_c[S+1], {(S-1){~fb_c[S+1]}}} : fb_c[S-1:0];

  assign wr_en   = (state_r == ST_WB);
  assign wr_addr = wr_idx_r;
  assign wr_data = fb_sat_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_idx_r    <= '0;
      lp_prev_r   <= '0;
      ap_prev_r   <= '0;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_if.ready && (state_r != ST_PUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            x_r    <= in_if.sample_in;
            zero_r <= !cfg.enabled;
            if (cfg.enabled) begin
              state_r <= ST_SUM;
            end else begin
              o_r     <= '0;
              state_r <= ST_PUT;
            end
          end
        end
        ST_SUM: begin
          w_r     <= w_c;
          diff_r  <= diff_c;
          state_r <= ST_LPMUL;
        end
        ST_LPMUL: begin
          lp_prod_r <= diff_r * weight_s;
          state_r   <= ST_LPADD;
        end
        ST_LPADD: begin
          y_r       <= y_c;
          lp_prev_r <= w_r;
          state_r   <= ST_APMUL;
        end
        ST_APMUL: begin
          ap_prod_r <= y_r * cfg.allpass_coef;
          state_r   <= ST_OUT;
        end
        ST_OUT: begin
          o_r     <= o_c;
          state_r <= ST_PUT;
        end
        ST_PUT: begin
          ap2_prod_r <= o_r * cfg.allpass_coef;
          fb_prod_r  <= o_r * gain_s;
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= o_r;
            state_r     <= zero_r ? ST_IDLE : ST_WB;
          end
        end
        ST_WB: begin
          ap_prev_r <= ap_sat_c;
          wr_idx_r  <= wr_idx_r + 1'b1;
          state_r   <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
